// ===== hdl/csf_pkg.sv =====
// csf_pkg: shared constants and types for the coprime set factor filter.
// No dependencies.
`timescale 1ns / 1ps
package csf_pkg;
  localparam int unsigned MAX_VALUE = 65536;
  localparam int unsigned VAL_W = $clog2(MAX_VALUE);
  localparam int unsigned ADDR_W = VAL_W;
  localparam int unsigned QDEPTH = 2;

  typedef logic [15:0] value_t;

  // front-to-back queue entry: a trivial value is answered without factoring
  typedef struct packed {
    logic trivial;
    logic triv_res;
    logic [ADDR_W-1:0] val;
  } job_t;
endpackage

// ===== hdl/csf_if.sv =====
// csf_word_if: valid/ready channel carrying one word of width W.
// No dependencies.
`timescale 1ns / 1ps
interface csf_word_if #(parameter int W = 16);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/csf_front.sv =====
// csf_front: accepts values, classifies trivial ones, queues jobs.
// Depends on csf_pkg.
`timescale 1ns / 1ps
module csf_front import csf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_valid,
  output logic   in_ready,
  input  value_t in_value,
  output logic   q_valid,
  input  logic   q_pop,
  output job_t   q_head
);
  localparam int unsigned CW = $clog2(QDEPTH+1);
  job_t q_r [QDEPTH];
  logic [CW-1:0] cnt_r;
  logic rd_r, wr_r;
  logic push;
  job_t j;

  assign in_ready = en && (cnt_r != CW'(QDEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = cnt_r != '0;
  assign q_head = q_r[rd_r];

  always_comb begin
    j.trivial = (in_value < 16'd2) || (32'(in_value) >= MAX_VALUE);
    j.triv_res = in_value < 16'd2;
    j.val = in_value[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= j;
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (q_pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + CW'(push) - CW'(q_pop);
    end
  end
endmodule

// ===== hdl/csf_back.sv =====
// csf_back: sieve fill after reset, then factoring, clash check and marking.
// Depends on csf_pkg. Holds the factor table and the used-prime bitmap.
`timescale 1ns / 1ps
module csf_back import csf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  output logic ready_init,
  input  logic q_valid,
  output logic q_pop,
  input  job_t q_head,
  output logic out_valid,
  input  logic out_ready,
  output logic out_accepted
);
  typedef enum logic [11:0] {
    S_CLR  = 12'b000000000001, S_SI   = 12'b000000000010,
    S_SIR  = 12'b000000000100, S_SJ   = 12'b000000001000,
    S_SJR  = 12'b000000010000, S_IDLE = 12'b000000100000,
    S_LK   = 12'b000001000000, S_LKR  = 12'b000010000000,
    S_DIV  = 12'b000100000000, S_CHK  = 12'b001000000000,
    S_MARK = 12'b010000000000, S_OUT  = 12'b100000000000
  } st_t;

  localparam int unsigned NP = 24;
  localparam int unsigned BW = $clog2(ADDR_W);
  st_t st_r;
  logic [ADDR_W:0] i_r, j_r;
  logic [ADDR_W-1:0] lft [MAX_VALUE];
  logic used [MAX_VALUE];
  logic [ADDR_W-1:0] t_rd_r;
  logic u_rd_r;
  logic [ADDR_W-1:0] t_addr, u_addr, t_wa, u_wa, t_wd;
  logic t_we, u_we, u_wd;
  logic [ADDR_W-1:0] x_r, p_r, q_r;
  logic [ADDR_W-1:0] pr_r [NP];
  logic [4:0] cnt_r, k_r;
  logic clash_r, res_r;
  logic [BW-1:0] b_r;     // division bit index
  logic [ADDR_W:0] rem_r;
  logic [ADDR_W:0] rtry;
  logic div_ge, div_exact;

  always_ff @(posedge clk) begin
    if (t_we) lft[t_wa] <= t_wd;
    t_rd_r <= lft[t_addr];
    if (u_we) used[u_wa] <= u_wd;
    u_rd_r <= used[u_addr];
  end

  assign ready_init = st_r != S_CLR && st_r != S_SI && st_r != S_SIR
                      && st_r != S_SJ && st_r != S_SJR;
  assign out_valid = st_r == S_OUT;
  assign out_accepted = res_r;
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign rtry = {rem_r[ADDR_W-1:0], x_r[b_r]};
  assign div_ge = rtry >= {1'b0, p_r};
  // zero remainder after the last bit
  assign div_exact = (rtry == {1'b0, p_r}) || (rtry == '0);

  always_comb begin
    t_addr = '0; u_addr = pr_r[k_r];
    t_we = 1'b0; u_we = 1'b0; t_wa = '0; u_wa = '0; t_wd = '0; u_wd = 1'b0;
    unique case (st_r)
      S_CLR: begin
        t_we = 1'b1; t_wa = i_r[ADDR_W-1:0];
        u_we = 1'b1; u_wa = i_r[ADDR_W-1:0];
      end
      S_SI: t_addr = i_r[ADDR_W-1:0];
      S_SIR: begin
        t_we = (t_rd_r == '0); t_wa = i_r[ADDR_W-1:0]; t_wd = i_r[ADDR_W-1:0];
      end
      S_SJ: t_addr = j_r[ADDR_W-1:0];
      S_SJR: begin
        t_we = (t_rd_r == '0); t_wa = j_r[ADDR_W-1:0]; t_wd = i_r[ADDR_W-1:0];
      end
      S_LK: t_addr = x_r;
      S_MARK: begin
        u_we = 1'b1; u_wa = pr_r[k_r]; u_wd = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; i_r <= '0;
    end else begin
      unique case (st_r)
        S_CLR: begin
          if (i_r == (ADDR_W+1)'(MAX_VALUE-1)) begin
            i_r <= (ADDR_W+1)'(2); st_r <= S_SI;
          end else i_r <= i_r + (ADDR_W+1)'(1);
        end
        S_SI: st_r <= S_SIR;
        S_SIR: begin
          if (t_rd_r == '0) begin
            j_r <= i_r + i_r; st_r <= S_SJ;
          end else if (i_r == (ADDR_W+1)'(MAX_VALUE-1)) st_r <= S_IDLE;
          else begin
            i_r <= i_r + (ADDR_W+1)'(1); st_r <= S_SI;
          end
        end
        S_SJ: begin
          if (j_r >= (ADDR_W+1)'(MAX_VALUE)) begin
            if (i_r == (ADDR_W+1)'(MAX_VALUE-1)) st_r <= S_IDLE;
            else begin
              i_r <= i_r + (ADDR_W+1)'(1); st_r <= S_SI;
            end
          end else st_r <= S_SJR;
        end
        S_SJR: begin
          j_r <= j_r + i_r; st_r <= S_SJ;
        end
        S_IDLE: if (q_valid) begin
          if (q_head.trivial) begin
            res_r <= q_head.triv_res; st_r <= S_OUT;
          end else begin
            x_r <= q_head.val; cnt_r <= '0; clash_r <= 1'b0; st_r <= S_LK;
          end
        end
        S_LK: st_r <= S_LKR;
        S_LKR: begin
          p_r <= t_rd_r;
          if (cnt_r < 5'(NP)) begin
            pr_r[cnt_r] <= t_rd_r; cnt_r <= cnt_r + 5'd1;
          end
          rem_r <= '0; q_r <= '0; b_r <= BW'(ADDR_W-1); st_r <= S_DIV;
        end
        S_DIV: begin
          // restoring divide x / p, one bit per cycle
          if (b_r == '0) begin
            if (div_exact) begin
              // exact: keep dividing by p
              x_r <= {q_r[ADDR_W-1:1], div_ge};
              rem_r <= '0; q_r <= '0; b_r <= BW'(ADDR_W-1);
            end else if (x_r <= {{(ADDR_W-1){1'b0}}, 1'b1}) begin
              k_r <= '0; st_r <= S_CHK;
            end else st_r <= S_LK;
          end else begin
            rem_r <= div_ge ? rtry - {1'b0, p_r} : rtry;
            q_r[b_r] <= div_ge;
            b_r <= b_r - BW'(1);
          end
        end
        S_CHK: begin
          // u_rd_r holds used[pr_r[k_r-1]], registered from the previous cycle's address
          if (k_r != '0 && u_rd_r) clash_r <= 1'b1;
          if (k_r == cnt_r) begin
            k_r <= '0;
            if (clash_r || (k_r != '0 && u_rd_r)) begin
              res_r <= 1'b0; st_r <= S_OUT;
            end else st_r <= S_MARK;
          end else k_r <= k_r + 5'd1;
        end
        S_MARK: begin
          if (k_r == cnt_r - 5'd1) begin
            res_r <= 1'b1; st_r <= S_OUT;
          end else k_r <= k_r + 5'd1;
        end
        S_OUT: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_CLR;
      endcase
    end
  end
endmodule

// ===== hdl/coprime_set_factor_filter.sv =====
// Coprime set filter: after reset clears the factor table and bitmap and runs
// the sieve; in_ready stays low till then. Per value: an idle state; per
// distinct prime p a lookup and bit-serial divides while p divides exactly;
// a check against the bitmap and, if no clash, marking; an output state.
// Values 0, 1 go from idle to output. One value in the back unit at a time,
// a two-entry queue decouples input. Reset is synchronous, active low.
`timescale 1ns / 1ps
module coprime_set_factor_filter import csf_pkg::*; (
  input logic clk,
  input logic rst_n,
  csf_word_if.sink in_ch,
  csf_word_if.source out_ch
);
  logic rdy, qv, qp;
  job_t qh;

  csf_front u_front (
    .clk, .rst_n, .en(rdy),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_value(in_ch.data),
    .q_valid(qv), .q_pop(qp), .q_head(qh)
  );

  csf_back u_back (
    .clk, .rst_n, .ready_init(rdy),
    .q_valid(qv), .q_pop(qp), .q_head(qh),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_accepted(out_ch.data)
  );
endmodule
